// ----- rtl/hrr_pkg.sv -----
// Shared types and constants for the Householder row reflector.
// No dependencies; every other file of the block but hrr_ram refers to this package.
`default_nettype none

package hrr_pkg;

   // Fixed point format of the reflector arithmetic.
   localparam int FRAC_BITS   = 16;
   // 2*dot has 2*FRAC_BITS fraction bits less one for the doubling.
   localparam int SCALE_SHIFT = 2 * FRAC_BITS - 1 - FRAC_BITS;

   // Field widths fixed by the external interface.
   localparam int BUS_W = 32;
   localparam int COL_W = 6;
   localparam int LEN_W = 7;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COLUMN = 1'd1;

   localparam logic [LEN_W-1:0] RESET_ROW_LENGTH   = 7'd64;
   localparam logic [COL_W-1:0] RESET_FIRST_COLUMN = 6'd0;

   typedef enum logic {
      OP_VECTOR = 1'b0,
      OP_ROW    = 1'b1
   } opcode_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic             is_row;
      logic [BUS_W-1:0] value;   // already sign extended from the element width
   } cmd_type;

   // Configuration as seen by the back part.
   typedef struct packed {
      logic             clear;      // row length written this cycle
      logic [COL_W-1:0] last_idx;   // effective row length minus one
      logic [COL_W-1:0] first_col;
   } cfg_type;

   typedef struct packed {
      logic [BUS_W-1:0] value;
      logic [COL_W-1:0] col;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic ready;      // back part takes requests from the queue
      logic emitting;   // back part is streaming out a finished row
   } bk_status_type;

endpackage

`default_nettype wire

// ----- rtl/hrr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module hrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/hrr_front.sv -----
// Front part: registers each incoming request and classifies it.
// Depends on hrr_pkg.
`default_nettype none

module hrr_front #(
   parameter int ELEMENT_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic                    in_opcode,
   input  wire logic [hrr_pkg::BUS_W-1:0] in_value,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output hrr_pkg::cmd_type             out_cmd
);

   logic             vld_ff;
   logic             vld_in;
   hrr_pkg::cmd_type cmd_ff;
   hrr_pkg::cmd_type cmd_in;
   logic             take;

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Only the low element-width bits carry the value; sign extend them.
   always_comb begin
      cmd_in.is_row = (in_opcode == hrr_pkg::OP_ROW);
      cmd_in.value  = hrr_pkg::BUS_W'($signed(in_value[ELEMENT_WIDTH-1:0]));
   end

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_cmd   = cmd_ff;

endmodule

`default_nettype wire

// ----- rtl/hrr_queue.sv -----
// Short request queue between the front and back parts.
// Depends on hrr_pkg.
`default_nettype none

module hrr_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   output logic                           push_ready,
   input  wire hrr_pkg::cmd_type          push_cmd,
   output logic                           pop_valid,
   input  wire logic                      pop_ready,
   output hrr_pkg::cmd_type               pop_cmd,
   output logic [hrr_pkg::QCNT_W-1:0]     count
);

   localparam int PTR_W = $clog2(hrr_pkg::QUEUE_DEPTH);

   hrr_pkg::cmd_type             slot_ff [hrr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff;
   logic [PTR_W-1:0]             rd_ptr_ff;
   logic [hrr_pkg::QCNT_W-1:0]   count_ff;
   logic [hrr_pkg::QCNT_W-1:0]   count_in;
   logic                         push;
   logic                         pop;

   assign push_ready = (count_ff != hrr_pkg::QCNT_W'(hrr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign count   = count_ff;

endmodule

`default_nettype wire

// ----- rtl/hrr_back.sv -----
// Back part: vector and row stores, dot product accumulation and the row update.
// Depends on hrr_pkg and hrr_ram.
`default_nettype none

module hrr_back #(
   parameter int MAX_ROW_LENGTH = 64,
   parameter int ELEMENT_WIDTH  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hrr_pkg::cfg_type       cfg,
   input  wire logic                   cmd_valid,
   output logic                        cmd_ready,
   input  wire hrr_pkg::cmd_type       cmd,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output hrr_pkg::rsp_type            rsp,
   output hrr_pkg::bk_status_type      status
);

   localparam int EW = ELEMENT_WIDTH;
   localparam int IW = $clog2(MAX_ROW_LENGTH);
   localparam int PW = hrr_pkg::BUS_W + EW;          // product width
   localparam int TW = PW - hrr_pkg::FRAC_BITS;      // rounded term width
   localparam int DW = TW + 1;                       // difference width
   localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (hrr_pkg::FRAC_BITS - 1);
   localparam logic signed [63:0]   SCALE_HALF = 64'(1) << (hrr_pkg::SCALE_SHIFT - 1);

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_FLUSH = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] sum;
      sum = a + b;
      if ((a[63] == b[63]) && (sum[63] != a[63])) begin
         sat_add64 = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = sum;
      end
   endfunction

   state_type                state_ff, state_in;
   logic [IW-1:0]            vec_pos_ff, vec_pos_in;
   logic [IW-1:0]            row_pos_ff, row_pos_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic signed [EW-1:0]     x_s1_ff;
   logic                     s1_vld_ff;
   logic                     s2_vld_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [31:0]       scale_ff, scale_in;
   logic [IW-1:0]            k_ff;
   logic                     issued_ff;
   logic                     e1_vld_ff, e1_last_ff, e1_act_ff;
   logic [IW-1:0]            e1_col_ff;
   logic                     e2_vld_ff, e2_last_ff, e2_act_ff;
   logic [IW-1:0]            e2_col_ff;
   logic signed [EW-1:0]     e2_row_ff;
   logic                     out_vld_ff;
   hrr_pkg::rsp_type         out_ff, out_in;

   logic [IW-1:0]            last_idx;
   logic                     st_run, st_flush, st_emit;
   logic                     pop, pop_row, pop_vec;
   logic                     row_active;
   logic                     adv, issue, flush_done, emit_done;
   logic [EW-1:0]            vec_rd, row_rd;
   logic [IW-1:0]            vec_rd_addr;
   logic signed [31:0]       mul_a;
   logic signed [PW-1:0]     mul_p;
   logic signed [63:0]       rnd_acc, shifted;
   logic signed [PW-1:0]     rnd;
   logic signed [TW-1:0]     term;
   logic signed [DW-1:0]     diff;
   logic signed [EW-1:0]     y_sat, y;

   assign last_idx = cfg.last_idx[IW-1:0];
   assign st_run   = (state_ff == ST_RUN);
   assign st_flush = (state_ff == ST_FLUSH);
   assign st_emit  = (state_ff == ST_EMIT);

   assign cmd_ready  = st_run;
   assign pop        = cmd_valid && cmd_ready;
   assign pop_row    = pop && cmd.is_row;
   assign pop_vec    = pop && !cmd.is_row;
   assign row_active = hrr_pkg::COL_W'(row_pos_ff) >= cfg.first_col;

   // The emission pipeline moves as one whenever the output register can take a result.
   assign adv        = !out_vld_ff || rsp_ready;
   assign issue      = st_emit && !issued_ff && adv;
   assign flush_done = st_flush && !s1_vld_ff && !s2_vld_ff;
   assign emit_done  = st_emit && issued_ff && !e1_vld_ff && !e2_vld_ff;

   assign vec_rd_addr = st_emit ? k_ff : row_pos_ff;

   hrr_ram #(.WIDTH(EW), .DEPTH(MAX_ROW_LENGTH)) u_vec_ram (
      .clock   (clock),
      .wr_en   (pop_vec),
      .wr_addr (vec_pos_ff),
      .wr_data (cmd.value[EW-1:0]),
      .rd_en   (pop_row || issue),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd)
   );

   hrr_ram #(.WIDTH(EW), .DEPTH(MAX_ROW_LENGTH)) u_row_ram (
      .clock   (clock),
      .wr_en   (pop_row),
      .wr_addr (row_pos_ff),
      .wr_data (cmd.value[EW-1:0]),
      .rd_en   (issue),
      .rd_addr (k_ff),
      .rd_data (row_rd)
   );

   // One multiplier serves both the dot product and the row update.
   assign mul_a = st_emit ? scale_ff : 32'(x_s1_ff);
   assign mul_p = mul_a * $signed(vec_rd);

   // Scale factor 2*dot, rounded half up and clamped to 32 bits.
   always_comb begin
      rnd_acc = sat_add64(acc_ff, SCALE_HALF);
      shifted = rnd_acc >>> hrr_pkg::SCALE_SHIFT;
      if ((&shifted[63:31]) || !(|shifted[63:31])) begin
         scale_in = shifted[31:0];
      end else begin
         scale_in = shifted[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end
   end

   // Row update: round the term, subtract, saturate to EW; inactive columns unchanged.
   always_comb begin
      rnd  = prod_ff + HALF_LSB;
      term = TW'(rnd >>> hrr_pkg::FRAC_BITS);
      diff = DW'(e2_row_ff) - DW'(term);
      if ((&diff[DW-1:EW-1]) || !(|diff[DW-1:EW-1])) begin
         y_sat = diff[EW-1:0];
      end else begin
         y_sat = diff[DW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
      end
      y            = e2_act_ff ? y_sat : e2_row_ff;
      out_in.value = 32'(y);
      out_in.col   = hrr_pkg::COL_W'(e2_col_ff);
      out_in.last  = e2_last_ff;
   end

   always_comb begin
      state_in   = state_ff;
      vec_pos_in = vec_pos_ff;
      row_pos_in = row_pos_ff;
      acc_in     = acc_ff;
      if (s2_vld_ff) begin
         acc_in = sat_add64(acc_ff, 64'(prod_ff));
      end
      case (state_ff)
         ST_RUN: begin
            if (pop_vec) begin
               vec_pos_in = (vec_pos_ff == last_idx) ? '0 : vec_pos_ff + 1'b1;
            end
            if (pop_row) begin
               if (row_pos_ff == last_idx) begin
                  row_pos_in = '0;
                  state_in   = ST_FLUSH;
               end else begin
                  row_pos_in = row_pos_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (flush_done) begin
               acc_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      if (cfg.clear) begin
         vec_pos_in = '0;
         row_pos_in = '0;
         acc_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         vec_pos_ff <= '0;
         row_pos_ff <= '0;
         acc_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         issued_ff  <= 1'b0;
         k_ff       <= '0;
         e1_vld_ff  <= 1'b0;
         e2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vec_pos_ff <= vec_pos_in;
         row_pos_ff <= row_pos_in;
         acc_ff     <= acc_in;
         s1_vld_ff  <= pop_row && row_active;
         s2_vld_ff  <= s1_vld_ff;
         if (flush_done) begin
            k_ff      <= '0;
            issued_ff <= 1'b0;
         end else if (issue) begin
            k_ff      <= k_ff + 1'b1;
            issued_ff <= (k_ff == last_idx);
         end
         if (adv) begin
            e1_vld_ff  <= issue;
            e2_vld_ff  <= e1_vld_ff;
            out_vld_ff <= e2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_row) begin
         x_s1_ff <= cmd.value[EW-1:0];
      end
      if (!st_emit || adv) begin
         prod_ff <= mul_p;
      end
      if (flush_done) begin
         scale_ff <= scale_in;
      end
      if (adv) begin
         e1_col_ff  <= k_ff;
         e1_last_ff <= (k_ff == last_idx);
         e1_act_ff  <= hrr_pkg::COL_W'(k_ff) >= cfg.first_col;
         e2_col_ff  <= e1_col_ff;
         e2_last_ff <= e1_last_ff;
         e2_act_ff  <= e1_act_ff;
         e2_row_ff  <= $signed(row_rd);
         out_ff     <= out_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp             = out_ff;
   assign status.ready    = st_run;
   assign status.emitting = st_emit;

endmodule

`default_nettype wire

// ----- rtl/householder_reflect_rows.sv -----
// Top level of the Householder row reflector: ports, configuration registers
// and the chain front part -> queue -> back part. Depends on hrr_pkg,
// hrr_front, hrr_queue and hrr_back (which uses hrr_ram).
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_tvalid/tready     tdata: element_value; tuser: opcode
// rsp       out        rsp_tvalid/tready     tdata: result_value, column_index; tlast
// csr       in         csr_we (no wait)      csr_index, csr_wdata
//
// Each request is registered by the front part and queued; the back part takes one
// queued request per cycle while it gathers a row. For each row the back part
// accumulates the dot product, finishes it and forms the scale, issues the emission
// reads through the shared multiplier and waits while the emission pipeline empties.
// Reset is synchronous and clears control state only; the vector and row stores
// hold whatever was written last and need no clearing pass.
// A stalled result holds the emission pipeline; the front part and queue keep
// taking requests until the queue is full.

module householder_reflect_rows #(
   parameter int MAX_ROW_LENGTH = 64,
   parameter int ELEMENT_WIDTH  = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [31:0]                       req_tdata,   // [31:0] element_value
   input  wire logic [0:0]                        req_tuser,   // [0] opcode
   // Result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [39:0]                            rsp_tdata,   // [31:0] result_value,
                                                               // [37:32] column_index
   output logic                                   rsp_tlast,   // last_of_row
   // Configuration write port
   input  wire logic                              csr_we,
   input  wire logic [hrr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hrr_pkg::LEN_W-1:0]         csr_wdata
);

   logic [hrr_pkg::LEN_W-1:0]   row_length_ff, row_length_in;
   logic [hrr_pkg::COL_W-1:0]   first_col_ff, first_col_in;
   logic [hrr_pkg::COL_W-1:0]   last_idx;
   hrr_pkg::cfg_type            cfg;

   logic                        front_vld;
   hrr_pkg::cmd_type            front_cmd;
   logic                        q_push_ready;
   logic                        q_vld;
   hrr_pkg::cmd_type            q_cmd;
   logic [hrr_pkg::QCNT_W-1:0]  q_count;
   logic                        bk_ready;
   hrr_pkg::rsp_type            bk_rsp;
   hrr_pkg::bk_status_type      bk_status;

   // Config registers. The user must write only while the block is idle (unchecked).
   always_comb begin
      row_length_in = row_length_ff;
      first_col_in  = first_col_ff;
      if (csr_we) begin
         case (csr_index)
            hrr_pkg::CSR_ROW_LENGTH:   row_length_in = csr_wdata;
            hrr_pkg::CSR_FIRST_COLUMN: first_col_in  = csr_wdata[hrr_pkg::COL_W-1:0];
            default: begin
               row_length_in = row_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= hrr_pkg::RESET_ROW_LENGTH;
         first_col_ff  <= hrr_pkg::RESET_FIRST_COLUMN;
      end else begin
         row_length_ff <= row_length_in;
         first_col_ff  <= first_col_in;
      end
   end

   // A length of zero behaves as one, and lengths beyond the store depth are clamped.
   always_comb begin
      if (row_length_ff == '0) begin
         last_idx = '0;
      end else if (row_length_ff > hrr_pkg::LEN_W'(MAX_ROW_LENGTH)) begin
         last_idx = hrr_pkg::COL_W'(MAX_ROW_LENGTH - 1);
      end else begin
         last_idx = hrr_pkg::COL_W'(row_length_ff - 1'b1);
      end
   end

   // Rewriting the row length restarts both the vector load and the current row.
   assign cfg.clear     = csr_we && (csr_index == hrr_pkg::CSR_ROW_LENGTH);
   assign cfg.last_idx  = last_idx;
   assign cfg.first_col = first_col_ff;

   hrr_front #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_opcode (req_tuser[0]),
      .in_value  (req_tdata),
      .out_valid (front_vld),
      .out_ready (q_push_ready),
      .out_cmd   (front_cmd)
   );

   hrr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_vld),
      .push_ready (q_push_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (q_vld),
      .pop_ready  (bk_ready),
      .pop_cmd    (q_cmd),
      .count      (q_count)
   );

   hrr_back #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .ELEMENT_WIDTH  (ELEMENT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (q_vld),
      .cmd_ready (bk_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (bk_rsp),
      .status    (bk_status)
   );

   assign rsp_tdata = {2'b00, bk_rsp.col, bk_rsp.value};
   assign rsp_tlast = bk_rsp.last;

   // The queue never holds more requests than it has slots.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= hrr_pkg::QCNT_W'(hrr_pkg::QUEUE_DEPTH))
      else $error("request queue overfilled");

   // A request held by the front part is not lost or altered while the queue is full.
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      front_vld && !q_push_ready |=> front_vld && $stable(front_cmd))
      else $error("front request changed while stalled");

   // While a row is being emitted the back part takes nothing from the queue.
   a_no_pop_in_emit: assert property (@(posedge clock) disable iff (reset)
      bk_status.emitting |=> q_count >= $past(q_count))
      else $error("queue drained during row emission");

   // The back part never accepts a request while it is emitting.
   a_ready_vs_emit: assert property (@(posedge clock) disable iff (reset)
      bk_status.ready |-> !bk_status.emitting)
      else $error("back part ready during emission");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for householder_reflect_rows: streams reflector vectors and
// matrix rows, predicts every reflected row element and compares each result.
// Depends on hrr_pkg and the householder_reflect_rows RTL only.
`timescale 1ns / 1ps

module tb;

   // Clock period in ns, and the cycle counts of reset, waiting and the receiver hold-off.
   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 7;
   // This is comfortably more than the block needs to finish a full-length row, plus
   // whatever sits in the queue, and to swallow stray requests.
   localparam int SETTLE_CYCLES = 200;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT     = 400000;
   localparam int HOLD_CYCLES   = 400;

   localparam longint ELEM_MAX = 64'sd2147483647;
   localparam longint ELEM_MIN = -64'sd2147483648;
   localparam longint DOT_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint DOT_MIN  = 64'sh8000_0000_0000_0000;

   // Random phases: row length as written (zero included) and first column,
   // where -1 asks for a random one.
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_LEN [PHASE_COUNT] = '{3, 8, 0, 5, 12, 2, 6, 7};
   localparam int PHASE_FC  [PHASE_COUNT] = '{0, 3, 0, 5, 1, 1, 2, -1};
   // The phase that runs with no idling on either side.
   localparam int BURST_PHASE = 4;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [31:0]                   req_tdata;
   logic [0:0]                    req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [39:0]                   rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we;
   logic [hrr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [hrr_pkg::LEN_W-1:0]     csr_wdata;

   // Shadow of the block: configuration, positions, accumulator and stores.
   logic [hrr_pkg::LEN_W-1:0]     row_length_shadow;
   logic [hrr_pkg::COL_W-1:0]     first_column_shadow;
   int unsigned                   vector_pos;
   int unsigned                   row_pos;
   longint                        dot_sum;
   logic [31:0]                   vector_mem [64];
   logic [31:0]                   row_mem    [64];
   bit                            vector_written [64];

   // Reflected row elements still to come out of the block, oldest first.
   hrr_pkg::rsp_type              reflected_q [$];

   int                            failures;
   int                            rsp_hold_left;
   bit                            no_idle;

   householder_reflect_rows DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Arithmetic helpers of the predictor.
   // ------------------------------------------------------------------------

   // Signed 64-bit addition that sticks at the limits instead of wrapping.
   function automatic longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? DOT_MIN : DOT_MAX;
      end
      return s;
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // Zero behaves as a single element and anything past 64 as a full row.
   function automatic int unsigned effective_length();
      if (row_length_shadow == 0) begin
         return 1;
      end
      if (row_length_shadow > 64) begin
         return 64;
      end
      return row_length_shadow;
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: called once for every request the block accepts. Vector loads
   // only fill the store; a row element from the first column on adds its product to the dot
   // product, and the last one of a row turns the whole buffered row into expectations.
   // ------------------------------------------------------------------------
   task automatic reflect_request(input hrr_pkg::opcode_type op, input logic [31:0] value);
      int unsigned      len;
      int unsigned      c;
      longint           x;
      longint           scale;
      longint           r;
      longint           p;
      longint           t;
      longint           y;
      hrr_pkg::rsp_type item;
      len = effective_length();
      x   = $signed(value);
      if (op == hrr_pkg::OP_VECTOR) begin
         vector_mem[vector_pos]     = value;
         vector_written[vector_pos] = 1'b1;
         // Loading more than a row length of elements wraps to element zero.
         vector_pos = (vector_pos + 1 >= len) ? 0 : vector_pos + 1;
      end else begin
         c = row_pos;
         row_mem[c] = value;
         if (c >= first_column_shadow) begin
            dot_sum = sat_add(dot_sum, x * $signed(vector_mem[c]));
         end
         if (c + 1 < len) begin
            row_pos = c + 1;
         end else begin
            // Twice the dot product, brought back to 16 fraction bits with
            // rounding half up, then held to a 32-bit signed scale.
            scale = sat_add(dot_sum, longint'(1) << (hrr_pkg::SCALE_SHIFT - 1))
                    >>> hrr_pkg::SCALE_SHIFT;
            scale = clamp(scale, ELEM_MIN, ELEM_MAX);
            for (int unsigned k = 0; k < len; k++) begin
               r = $signed(row_mem[k]);
               y = r;
               if (k >= first_column_shadow) begin
                  p = scale * $signed(vector_mem[k]);
                  t = (p + (longint'(1) << (hrr_pkg::FRAC_BITS - 1))) >>> hrr_pkg::FRAC_BITS;
                  y = clamp(r - t, ELEM_MIN, ELEM_MAX);
               end
               item.value = y[31:0];
               item.col   = k[hrr_pkg::COL_W-1:0];
               item.last  = (k + 1 == len);
               reflected_q.push_back(item);
            end
            row_pos = 0;
            dot_sum = 0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus plumbing.
   // ------------------------------------------------------------------------

   // Mostly modest Q16.16 values so the reflection stays meaningful, with raw
   // random words and the extremes mixed in.
   function automatic logic [31:0] random_element();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      endcase
   endfunction

   // Offers one request and returns once it has been accepted. The valid line
   // is left high so that the next request may follow back to back; anything
   // that waits lowers it first.
   task automatic send_request(input hrr_pkg::opcode_type op, input logic [31:0] value);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 25) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid   = 1'b1;
      req_tuser[0] = op;
      req_tdata    = value;
      do begin
         @(posedge clock);
      end while (!req_tready);
      reflect_request(op, value);
   endtask

   // Stops offering, waits for every expected result and then lets the given
   // number of further cycles pass.
   task automatic wait_drained(input int settle);
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (reflected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (reflected_q.size() != 0) begin
         $error("%0d reflected elements never arrived", reflected_q.size());
         failures++;
         reflected_q.delete();
      end
      repeat (settle) @(posedge clock);
   endtask

   // Registers change only once the block has gone quiet. Writing the row
   // length also restarts the vector and row positions and the dot product.
   task automatic write_csr(input logic [hrr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hrr_pkg::LEN_W-1:0] value);
      wait_drained(SETTLE_CYCLES);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      if (idx == hrr_pkg::CSR_ROW_LENGTH) begin
         row_length_shadow = value;
         vector_pos        = 0;
         row_pos           = 0;
         dot_sum           = 0;
      end else if (idx == hrr_pkg::CSR_FIRST_COLUMN) begin
         first_column_shadow = value[hrr_pkg::COL_W-1:0];
      end
   endtask

   task automatic send_row(input int unsigned count);
      for (int unsigned k = 0; k < count; k++) begin
         send_request(hrr_pkg::OP_ROW, random_element());
      end
   endtask

   // ------------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------------

   // A four-element reflector of squared length about 1.25 applied to one row.
   task automatic test_basic_reflection();
      write_csr(hrr_pkg::CSR_ROW_LENGTH, 7'd4);
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd0);
      send_request(hrr_pkg::OP_VECTOR, 32'h0000_B505);
      send_request(hrr_pkg::OP_VECTOR, 32'hFFFF_4AFB);
      send_request(hrr_pkg::OP_VECTOR, 32'h0000_8000);
      send_request(hrr_pkg::OP_VECTOR, 32'h0000_0000);
      send_request(hrr_pkg::OP_ROW, 32'h0001_0000);
      send_request(hrr_pkg::OP_ROW, 32'h0002_0000);
      send_request(hrr_pkg::OP_ROW, 32'hFFFF_0000);
      send_request(hrr_pkg::OP_ROW, 32'h7FFF_FFFF);
   endtask

   // With the first column past the end of the row nothing is active, so the
   // row must come back exactly as it went in.
   task automatic test_inactive_columns();
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd63);
      send_request(hrr_pkg::OP_ROW, 32'h8000_0000);
      send_request(hrr_pkg::OP_ROW, 32'h7FFF_FFFF);
      send_request(hrr_pkg::OP_ROW, 32'hFFFF_FFFF);
      send_request(hrr_pkg::OP_ROW, 32'h0000_0001);
   endtask

   // The first column moves after half a row: the part of the dot product
   // already gathered is kept and the new column applies from there on.
   task automatic test_first_column_mid_row();
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd0);
      send_request(hrr_pkg::OP_ROW, 32'h0003_0000);
      send_request(hrr_pkg::OP_ROW, 32'hFFFE_8000);
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd2);
      send_request(hrr_pkg::OP_ROW, 32'h0000_4000);
      send_request(hrr_pkg::OP_ROW, 32'h0001_0000);
   endtask

   // A third load into a two-element vector overwrites element zero; the
   // extreme values then drive the scale and result saturation.
   task automatic test_vector_overrun();
      write_csr(hrr_pkg::CSR_ROW_LENGTH, 7'd2);
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd0);
      send_request(hrr_pkg::OP_VECTOR, 32'h1234_5678);
      send_request(hrr_pkg::OP_VECTOR, 32'h8000_0000);
      send_request(hrr_pkg::OP_VECTOR, 32'h7FFF_FFFF);
      send_request(hrr_pkg::OP_ROW, 32'h8000_0000);
      send_request(hrr_pkg::OP_ROW, 32'h7FFF_FFFF);
   endtask

   // A row length of zero behaves as a single-element row.
   task automatic test_zero_length();
      write_csr(hrr_pkg::CSR_ROW_LENGTH, 7'd0);
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd0);
      send_request(hrr_pkg::OP_VECTOR, 32'h0000_C000);
      send_request(hrr_pkg::OP_ROW, 32'h0001_8000);
   endtask

   // ------------------------------------------------------------------------
   // Random phases: each phase sets a configuration, loads a vector where one
   // is needed and then streams whole rows with the odd stray vector load.
   // Some phases end in a broken row that the next length write discards.
   // ------------------------------------------------------------------------
   task automatic test_random_phases();
      int unsigned len;
      int unsigned loads;
      int unsigned budget;
      int unsigned sent;
      int          fc;
      bit          need_full;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         fc = (PHASE_FC[ph] < 0) ? int'($urandom_range(0, 63)) : PHASE_FC[ph];
         write_csr(hrr_pkg::CSR_ROW_LENGTH, PHASE_LEN[ph][hrr_pkg::LEN_W-1:0]);
         write_csr(hrr_pkg::CSR_FIRST_COLUMN, fc[hrr_pkg::COL_W-1:0]);
         no_idle = (ph == BURST_PHASE);
         len = effective_length();
         need_full = 1'b0;
         for (int unsigned k = 0; k < len; k++) begin
            if (!vector_written[k]) begin
               need_full = 1'b1;
            end
         end
         // Every column a row can read must hold a loaded element.
         loads = need_full ? len : $urandom_range(0, 2);
         for (int unsigned k = 0; k < loads; k++) begin
            send_request(hrr_pkg::OP_VECTOR, random_element());
         end
         budget = (ph == BURST_PHASE) ? 24 : 4;
         sent = 0;
         while (sent < budget) begin
            for (int unsigned k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_request(hrr_pkg::OP_VECTOR, random_element());
               end
               send_request(hrr_pkg::OP_ROW, random_element());
               sent++;
            end
         end
         if (len > 1 && $urandom_range(0, 2) == 0) begin
            send_row($urandom_range(1, len - 1));
         end
         no_idle = 1'b0;
      end
   endtask

   // The receiver holds off for a long stretch while three rows are offered,
   // so the queue fills and the block has to stall its request side.
   task automatic test_backpressure();
      write_csr(hrr_pkg::CSR_ROW_LENGTH, 7'd8);
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd0);
      for (int k = 0; k < 8; k++) begin
         send_request(hrr_pkg::OP_VECTOR, random_element());
      end
      rsp_hold_left = HOLD_CYCLES;
      send_row(24);
   endtask

   // The sender stops after each row until the whole row has come back.
   task automatic test_drain_pause();
      write_csr(hrr_pkg::CSR_ROW_LENGTH, 7'd6);
      write_csr(hrr_pkg::CSR_FIRST_COLUMN, 6'd1);
      for (int k = 0; k < 3; k++) begin
         send_row(6);
         wait_drained(0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: idles at random, except in the burst phase, and obeys a long
   // hold-off when a test asks for one, counting it down cycle by cycle.
   // ------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready = no_idle || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: every accepted result is matched against the oldest expected
   // element, field by field.
   // ------------------------------------------------------------------------
   initial begin
      hrr_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (reflected_q.size() == 0) begin
               $error("result with nothing expected: value %h column %0d last %b",
                      rsp_tdata[31:0], rsp_tdata[37:32], rsp_tlast);
               failures++;
            end else begin
               want = reflected_q.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  $error("result_value: expected %h, got %h", want.value, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[37:32] !== want.col) begin
                  $error("column_index: expected %0d, got %0d", want.col, rsp_tdata[37:32]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_row: expected %b, got %b", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
      end
   end

   // Hard stop in case the block hangs somewhere.
   initial begin
      #(RUN_LIMIT * CLOCK_PERIOD);
      $display("FAIL householder_reflect_rows");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence: one reset, the directed tests, then the random and
   // pressure tests, and finally a drain before the verdict.
   // ------------------------------------------------------------------------
   initial begin
      req_tvalid          = 1'b0;
      req_tdata           = '0;
      req_tuser           = '0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      failures            = 0;
      rsp_hold_left       = 0;
      no_idle             = 1'b0;
      row_length_shadow   = hrr_pkg::RESET_ROW_LENGTH;
      first_column_shadow = hrr_pkg::RESET_FIRST_COLUMN;
      vector_pos          = 0;
      row_pos             = 0;
      dot_sum             = 0;
      for (int k = 0; k < 64; k++) begin
         vector_written[k] = 1'b0;
      end
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_reflection();
      test_inactive_columns();
      test_first_column_mid_row();
      test_vector_overrun();
      test_zero_length();
      test_random_phases();
      test_backpressure();
      test_drain_pause();

      wait_drained(SETTLE_CYCLES);
      if (failures == 0) begin
         $display("PASS householder_reflect_rows");
      end else begin
         $display("FAIL householder_reflect_rows");
      end
      $finish;
   end

endmodule

// ----- householder_reflect_rows.f -----
rtl/hrr_pkg.sv
rtl/hrr_ram.sv
rtl/hrr_front.sv
rtl/hrr_queue.sv
rtl/hrr_back.sv
rtl/householder_reflect_rows.sv
bench/tb.sv
